// ===== rtl/core/stable_priority_queue_top_defines.svh =====
// Assertion macros used by the checker file of the priority queue.
`ifndef STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SPQ_ASSERT_IMP(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SPQ_ASSERT_NXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/spq_pkg.sv =====
// Package: sizes, codes and controller-to-datapath command struct of the priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int PRI_W    = 32;
    localparam int OCC_W    = 5;

    // occupancy field carries the count modulo 2**OCC_W
    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;  // latch the input beat
        logic commit;   // apply the request to the store, load the result
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/stable_priority_queue_top.sv =====
// Top level of the stable bounded priority queue.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request per beat:
//   action 0 inserts (item_data, item_priority), action 1 removes the front.
//   Smaller priority is served first; equal priorities leave in arrival order.
//   Output channel (out_valid/out_ready) returns one result beat per request:
//   removed data and priority (zero unless a remove succeeded), status
//   (inserted, removed, empty on remove, full on insert) and occupancy after it.
// Sequencing:
//   The request is registered at the accepting edge and committed to the
//   sorted cell chain once the result register is free; out_valid rises
//   with the commit. The next request is not accepted before that commit:
//   in_ready stays low while the input register holds the request.
// Reset:
//   rst_n clears the entry count (queue empty) and the handshake state;
//   in_ready is high right after reset.
// Stall:
//   The result register holds while out_ready is low. One more request can be
//   accepted meanwhile; it waits in the input register until the result drains.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               action,
    input  wire logic signed [spq_pkg::DATA_W-1:0]  item_data,
    input  wire logic signed [spq_pkg::PRI_W-1:0]   item_priority,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [spq_pkg::DATA_W-1:0]       out_data,
    output logic signed [spq_pkg::PRI_W-1:0]        out_priority,
    output logic [1:0]                              status,
    output logic [spq_pkg::OCC_W-1:0]               occupancy
);

    // capture/commit strobes from the controller to the datapath
    spq_pkg::cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // sorted store: insert drops the new pair behind every entry with
    // priority <= its own; remove shifts the whole chain one cell forward
    spq_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (action),
        .item_data     (item_data),
        .item_priority (item_priority),
        .out_data      (out_data),
        .out_priority  (out_priority),
        .status        (status),
        .occupancy     (occupancy)
    );

endmodule

`default_nettype wire

// ===== rtl/core/spq_ctrl.sv =====
// Controller: handshake state machine that sequences capture and commit.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output spq_pkg::cmd_t      cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;
    logic   commit;

    assign accept   = in_valid && in_ready_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign commit   = (state_reg == S_EXEC) && out_free;

    always_comb
    begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = (out_valid_reg && !out_ready) || commit;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next    = S_EXEC;
                    in_ready_next = 1'b0;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next    = S_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready    = in_ready_reg;
    assign out_valid   = out_valid_reg;
    assign cmd.capture = accept;
    assign cmd.commit  = commit;

endmodule

`default_nettype wire

// ===== rtl/core/spq_datapath.sv =====
// Datapath: input register, sorted shift-register cell chain, count and result register.
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire spq_pkg::cmd_t                      cmd,
    input  wire logic                               action,
    input  wire logic signed [spq_pkg::DATA_W-1:0]  item_data,
    input  wire logic signed [spq_pkg::PRI_W-1:0]   item_priority,
    output logic signed [spq_pkg::DATA_W-1:0]       out_data,
    output logic signed [spq_pkg::PRI_W-1:0]        out_priority,
    output logic [1:0]                              status,
    output logic [spq_pkg::OCC_W-1:0]               occupancy
);

    localparam int CAP = spq_pkg::CAPACITY;
    localparam int CW  = spq_pkg::COUNT_W;

    // captured request
    logic                              act_reg;
    logic signed [spq_pkg::DATA_W-1:0] din_data_reg;
    logic signed [spq_pkg::PRI_W-1:0]  din_pri_reg;

    // cell 0 is the front of the queue
    logic signed [spq_pkg::DATA_W-1:0] cell_data_reg [CAP];
    logic signed [spq_pkg::PRI_W-1:0]  cell_pri_reg  [CAP];
    logic signed [spq_pkg::DATA_W-1:0] ins_data      [CAP];
    logic signed [spq_pkg::PRI_W-1:0]  ins_pri       [CAP];
    logic signed [spq_pkg::DATA_W-1:0] rem_data      [CAP];
    logic signed [spq_pkg::PRI_W-1:0]  rem_pri       [CAP];
    logic [CAP-1:0]                    stay;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic signed [spq_pkg::DATA_W-1:0] out_data_reg;
    logic signed [spq_pkg::DATA_W-1:0] out_data_next;
    logic signed [spq_pkg::PRI_W-1:0]  out_pri_reg;
    logic signed [spq_pkg::PRI_W-1:0]  out_pri_next;
    spq_pkg::status_t                  status_reg;
    spq_pkg::status_t                  status_next;

    logic full;
    logic empty;
    logic do_insert;
    logic do_remove;

    assign full      = (count_reg == CW'(CAP));
    assign empty     = (count_reg == '0);
    assign do_insert = (act_reg == spq_pkg::ACT_INSERT) && !full;
    assign do_remove = (act_reg == spq_pkg::ACT_REMOVE) && !empty;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg      <= action;
            din_data_reg <= item_data;
            din_pri_reg  <= item_priority;
        end
    end

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(g);

        // held entry at or ahead of the new priority keeps its place (FIFO on ties)
        assign stay[g] = (IDX < count_reg) && (cell_pri_reg[g] <= din_pri_reg);

        if (g == 0) begin : g_head
            assign ins_data[g] = stay[g] ? cell_data_reg[g] : din_data_reg;
            assign ins_pri[g]  = stay[g] ? cell_pri_reg[g]  : din_pri_reg;
        end
        else begin : g_body
            assign ins_data[g] = stay[g]     ? cell_data_reg[g]   :
                                 stay[g - 1] ? din_data_reg       : cell_data_reg[g - 1];
            assign ins_pri[g]  = stay[g]     ? cell_pri_reg[g]    :
                                 stay[g - 1] ? din_pri_reg        : cell_pri_reg[g - 1];
        end

        if (g == CAP - 1) begin : g_tail
            assign rem_data[g] = cell_data_reg[g];
            assign rem_pri[g]  = cell_pri_reg[g];
        end
        else begin : g_mid
            assign rem_data[g] = cell_data_reg[g + 1];
            assign rem_pri[g]  = cell_pri_reg[g + 1];
        end

        always_ff @(posedge clk)
        begin
            if (cmd.commit && do_insert)
            begin
                cell_data_reg[g] <= ins_data[g];
                cell_pri_reg[g]  <= ins_pri[g];
            end
            else if (cmd.commit && do_remove)
            begin
                cell_data_reg[g] <= rem_data[g];
                cell_pri_reg[g]  <= rem_pri[g];
            end
        end
    end

    always_comb
    begin
        count_next    = count_reg;
        out_data_next = '0;
        out_pri_next  = '0;
        if (act_reg == spq_pkg::ACT_INSERT)
        begin
            if (full)
            begin
                status_next = spq_pkg::ST_FULL;
            end
            else
            begin
                status_next = spq_pkg::ST_INSERTED;
                count_next  = count_reg + CW'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = spq_pkg::ST_EMPTY;
            end
            else
            begin
                status_next   = spq_pkg::ST_REMOVED;
                count_next    = count_reg - CW'(1);
                out_data_next = cell_data_reg[0];
                out_pri_next  = cell_pri_reg[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg <= out_data_next;
            out_pri_reg  <= out_pri_next;
            status_reg   <= status_next;
            occupancy    <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign out_data     = out_data_reg;
    assign out_priority = out_pri_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

// ===== rtl/core/spq_checker.sv =====
// Port-level checker for the priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "stable_priority_queue_top_defines.svh"

module spq_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_ready,
    input wire logic                               action,
    input wire logic signed [spq_pkg::DATA_W-1:0]  item_data,
    input wire logic signed [spq_pkg::PRI_W-1:0]   item_priority,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic signed [spq_pkg::DATA_W-1:0]  out_data,
    input wire logic signed [spq_pkg::PRI_W-1:0]   out_priority,
    input wire logic [1:0]                         status,
    input wire logic [spq_pkg::OCC_W-1:0]          occupancy
);

    `SPQ_ASSERT_IMP(a_empty_zero, out_valid && (status == spq_pkg::ST_EMPTY), (occupancy == '0) && (out_data == '0) && (out_priority == '0))
    `SPQ_ASSERT_IMP(a_full_count, out_valid && (status == spq_pkg::ST_FULL), occupancy == spq_pkg::OCC_FULL)
    `SPQ_ASSERT_IMP(a_insert_zero, out_valid && (status == spq_pkg::ST_INSERTED), (out_data == '0) && (out_priority == '0) && (occupancy != '0))
    `SPQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data) && $stable(status) && $stable(occupancy))

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (.*);

`default_nettype wire

// ===== bench/stable_priority_queue_top_tb.sv =====
// Self-checking testbench for the stable bounded priority queue.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue_top_tb;

    localparam int RANDOM_ITEMS = 628;
    localparam int QUIET_TAIL   = 60;     // last requests run with no idling
    localparam int LONG_HOLD    = 80;     // receiver hold-off, in cycles
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct {
        logic                               action;
        logic signed [spq_pkg::DATA_W-1:0]  data;
        logic signed [spq_pkg::PRI_W-1:0]   prio;
        bit                                 drain_first;  // wait for all replies first
    } request_t;

    typedef struct {
        logic signed [spq_pkg::DATA_W-1:0]  data;
        logic signed [spq_pkg::PRI_W-1:0]   prio;
        spq_pkg::status_t                   status;
        logic [spq_pkg::OCC_W-1:0]          occ;
    } reply_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic                               action = spq_pkg::ACT_INSERT;
    logic signed [spq_pkg::DATA_W-1:0]  item_data = '0;
    logic signed [spq_pkg::PRI_W-1:0]   item_priority = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic signed [spq_pkg::DATA_W-1:0]  out_data;
    logic signed [spq_pkg::PRI_W-1:0]   out_priority;
    logic [1:0]                         status;
    logic [spq_pkg::OCC_W-1:0]          occupancy;

    request_t request_q[$];
    reply_t   reply_q[$];

    // Shadow of the sorted store, front entry at index 0.
    logic signed [spq_pkg::DATA_W-1:0]  held_data [spq_pkg::CAPACITY];
    logic signed [spq_pkg::PRI_W-1:0]   held_prio [spq_pkg::CAPACITY];
    int                                 held_count = 0;

    logic req_fired = 1'b0;     // request beat taken at the last rising edge
    int   beats_in = 0;
    int   error_count = 0;
    int   cycle_count = 0;
    int   gap_left = 0;
    int   ready_hold = 0;
    bit   long_hold_done = 1'b0;
    int   n_inserted = 0;
    int   n_removed = 0;
    int   n_empty = 0;
    int   n_full = 0;

    stable_priority_queue_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .item_data     (item_data),
        .item_priority (item_priority),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .out_priority  (out_priority),
        .status        (status),
        .occupancy     (occupancy)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Reset asserted from time zero, released away from the rising edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Applies one request to the shadow store and returns the reply it gives.
    // A new pair goes behind every entry of lower or equal priority value,
    // which keeps equal priorities in arrival order.
    function automatic reply_t serve_request(input request_t req);
        reply_t r;
        int     slot;
        r.data   = '0;
        r.prio   = '0;
        r.status = spq_pkg::ST_INSERTED;
        if (req.action == spq_pkg::ACT_INSERT)
        begin
            if (held_count >= spq_pkg::CAPACITY)
                r.status = spq_pkg::ST_FULL;
            else
            begin
                slot = 0;
                while (slot < held_count && held_prio[slot] <= req.prio)
                    slot++;
                for (int k = held_count; k > slot; k--)
                begin
                    held_data[k] = held_data[k-1];
                    held_prio[k] = held_prio[k-1];
                end
                held_data[slot] = req.data;
                held_prio[slot] = req.prio;
                held_count++;
            end
        end
        else
        begin
            if (held_count == 0)
                r.status = spq_pkg::ST_EMPTY;
            else
            begin
                r.data = held_data[0];
                r.prio = held_prio[0];
                for (int k = 1; k < held_count; k++)
                begin
                    held_data[k-1] = held_data[k];
                    held_prio[k-1] = held_prio[k];
                end
                held_count--;
                r.status = spq_pkg::ST_REMOVED;
            end
        end
        r.occ = spq_pkg::OCC_W'(held_count);
        return r;
    endfunction

    function automatic void add_request(input logic act, input logic [31:0] data,
                                        input logic [31:0] prio, input bit drain);
        request_t req;
        req.action      = act;
        req.data        = data;
        req.prio        = prio;
        req.drain_first = drain;
        request_q.push_back(req);
    endfunction

    // Sender: presents a new beat at the falling edge once the previous one
    // was taken. Random idle gaps between beats, none in the final stretch.
    always @(negedge clk)
    begin
        request_t req;
        logic     next_valid;
        next_valid = 1'b0;
        if (!rst_n)
            next_valid = 1'b0;
        else if (in_valid && !req_fired)
            next_valid = 1'b1;                // beat still waiting, hold it
        else if (gap_left > 0)
            gap_left--;
        else if (request_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 14) - 1;
        else if (request_q.size() > 0)
        begin
            // a marked request waits until every reply has drained
            if (!(request_q[0].drain_first && reply_q.size() != 0))
            begin
                req = request_q.pop_front();
                action        <= req.action;
                item_data     <= req.data;
                item_priority <= req.prio;
                next_valid    = 1'b1;
            end
        end
        in_valid <= next_valid;
    end

    // Receiver: random stalls, plus one long hold-off that backs the queue up
    // into the input channel while the sender keeps going.
    always @(negedge clk)
    begin
        logic next_ready;
        next_ready = 1'b1;
        if (!rst_n)
            next_ready = 1'b0;
        else if (ready_hold > 0)
        begin
            ready_hold--;
            next_ready = 1'b0;
        end
        else if (!long_hold_done && beats_in >= 100)
        begin
            long_hold_done = 1'b1;
            ready_hold = LONG_HOLD - 1;
            next_ready = 1'b0;
        end
        else if (request_q.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
        begin
            ready_hold = $urandom_range(1, 14) - 1;
            next_ready = 1'b0;
        end
        out_ready <= next_ready;
    end

    // Monitor: checks each result beat against the oldest reply, then predicts
    // the reply of a request beat taken at this edge.
    always @(posedge clk)
    begin
        reply_t   want;
        request_t req;
        req_fired <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (reply_q.size() == 0)
                begin
                    $error("result beat with no request outstanding: status %0d", status);
                    error_count++;
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (out_data !== want.data)
                    begin
                        $error("out_data: expected %0d, got %0d", want.data, out_data);
                        error_count++;
                    end
                    if (out_priority !== want.prio)
                    begin
                        $error("out_priority: expected %0d, got %0d", want.prio, out_priority);
                        error_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        error_count++;
                    end
                    if (occupancy !== want.occ)
                    begin
                        $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
                        error_count++;
                    end
                    case (want.status)
                        spq_pkg::ST_INSERTED: n_inserted++;
                        spq_pkg::ST_REMOVED:  n_removed++;
                        spq_pkg::ST_EMPTY:    n_empty++;
                        default:              n_full++;
                    endcase
                end
            end
            if (in_valid && in_ready)
            begin
                req.action      = action;
                req.data        = item_data;
                req.prio        = item_priority;
                req.drain_first = 1'b0;
                reply_q.push_back(serve_request(req));
                beats_in++;
            end
        end
    end

    // Watchdog on a cycle counter.
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d replies outstanding",
                 cycle_count, reply_q.size());
        $display("stable_priority_queue_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        int          ins_pct;
        int          pick;
        logic [31:0] prio;
        logic        act;

        // Directed: remove on empty (item fields ignored), then fill with
        // extreme priorities and ties, insert into a full store, drain some.
        add_request(spq_pkg::ACT_REMOVE, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'h7fff_ffff, 32'd0,         1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'd0,         32'h7fff_ffff, 1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'd1,         32'd5,         1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'd2,         32'd5,         1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'd3,         32'd5,         1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'd4,         32'd0,         1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'd5,         32'h8000_0000, 1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'd6,         32'h7fff_ffff, 1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'd7,         32'hffff_ffff, 1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'd8,         32'd1,         1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'd9,         32'd2,         1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'd10,        32'd3,         1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'd11,        32'hffff_fffe, 1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'd12,        32'd5,         1'b0);
        add_request(spq_pkg::ACT_INSERT, 32'd13,        32'h8000_0000, 1'b0);  // full, dropped
        add_request(spq_pkg::ACT_REMOVE, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
        add_request(spq_pkg::ACT_REMOVE, 32'd0,         32'd0,         1'b0);
        add_request(spq_pkg::ACT_REMOVE, $urandom,      $urandom,      1'b0);
        add_request(spq_pkg::ACT_REMOVE, $urandom,      $urandom,      1'b0);

        // Random: runs of 32 requests leaning toward inserts, toward removes or
        // balanced, so the store swings between empty and full. Priorities favor
        // a narrow band around zero to make ties common.
        ins_pct = 50;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 32 == 0)
            begin
                pick = $urandom_range(0, 2);
                ins_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
            end
            act = ($urandom_range(1, 100) <= ins_pct) ? spq_pkg::ACT_INSERT
                                                      : spq_pkg::ACT_REMOVE;
            pick = $urandom_range(0, 9);
            if (pick < 5)
                prio = $urandom_range(0, 4) - 2;
            else if (pick < 8)
                prio = $urandom;
            else if (pick == 8)
                prio = 32'h8000_0000;
            else
                prio = 32'h7fff_ffff;
            add_request(act, $urandom, prio, (i == 0) || (i == 300));
        end

        wait (rst_n);
        do
            @(posedge clk);
        while (request_q.size() != 0 || in_valid || reply_q.size() != 0);
        repeat (10) @(posedge clk);

        if (reply_q.size() != 0)
        begin
            $error("%0d replies never arrived", reply_q.size());
            error_count++;
        end
        $display("%0d requests: %0d inserted, %0d full drops, %0d removed, %0d empty removes",
                 beats_in, n_inserted, n_full, n_removed, n_empty);
        $display("random idling on both sides, one %0d-cycle output hold-off, drained pauses",
                 LONG_HOLD);
        if (error_count == 0)
            $display("stable_priority_queue_top_tb: done, clean");
        else
            $display("stable_priority_queue_top_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
